/* hw/rtl/mbet_pkg.sv */
// Shared types, constants and helpers for the escape-time pixel engine.
package mbet_pkg;

  localparam int COORD_W          = 32;
  localparam int ITER_BITS        = 10;
  localparam int PIXEL_INDEX_BITS = 11;
  localparam int GRAY_W           = 8;
  localparam int CFG_DATA_W       = 32;
  localparam int CFG_INDEX_W      = 3;
  localparam int PROD_W           = 2 * COORD_W;
  localparam int WIDE_W           = PROD_W + 2;

  localparam logic [CFG_INDEX_W-1:0] REG_LEFT_REAL = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TOP_IMAG  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_REAL = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_IMAG = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ITER  = 3'd4;

  localparam logic signed [COORD_W-1:0] LEFT_REAL_RST = -32'sd536870912;
  localparam logic signed [COORD_W-1:0] TOP_IMAG_RST  = 32'sd268435456;
  localparam logic signed [COORD_W-1:0] STEP_REAL_RST = 32'sd1007893;
  localparam logic signed [COORD_W-1:0] STEP_IMAG_RST = 32'sd896279;
  localparam logic [ITER_BITS-1:0]      MAX_ITER_RST  = 10'd400;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [PIXEL_INDEX_BITS-1:0] pixel_col;
    logic [PIXEL_INDEX_BITS-1:0] pixel_row;
  } pixel_in_t;

  typedef struct packed {
    logic [PIXEL_INDEX_BITS-1:0] pixel_col_out;
    logic [PIXEL_INDEX_BITS-1:0] pixel_row_out;
    logic [ITER_BITS-1:0]        iteration_count;
    logic [GRAY_W-1:0]           gray_level;
    logic                        inside_set;
  } pixel_out_t;

  typedef struct packed {
    coord_t               left_real;
    coord_t               top_imag;
    coord_t               step_real;
    coord_t               step_imag;
    logic [ITER_BITS-1:0] max_iterations;
  } cfg_regs_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP_RE,
    S_MAP_IM,
    S_LOAD,
    S_SQR,
    S_SQI,
    S_CROSS,
    S_UPD,
    S_DONE
  } state_t;

  function automatic coord_t sat_coord(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = {{(WIDE_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    lo = {{(WIDE_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};
    if (v > hi) begin
      sat_coord = hi[COORD_W-1:0];
    end else if (v < lo) begin
      sat_coord = lo[COORD_W-1:0];
    end else begin
      sat_coord = v[COORD_W-1:0];
    end
  endfunction

endpackage

/* hw/rtl/mbet_cfg.sv */
// Configuration register file for the view window and iteration limit.
module mbet_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [mbet_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mbet_pkg::CFG_DATA_W-1:0]    cfg_data,
  output mbet_pkg::cfg_regs_t                regs
);
  import mbet_pkg::*;

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_LEFT_REAL: regs_nxt.left_real      = cfg_data[COORD_W-1:0];
        REG_TOP_IMAG:  regs_nxt.top_imag       = cfg_data[COORD_W-1:0];
        REG_STEP_REAL: regs_nxt.step_real      = cfg_data[COORD_W-1:0];
        REG_STEP_IMAG: regs_nxt.step_imag      = cfg_data[COORD_W-1:0];
        REG_MAX_ITER:  regs_nxt.max_iterations = cfg_data[ITER_BITS-1:0];
        default:       regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.left_real      <= LEFT_REAL_RST;
      regs_r.top_imag       <= TOP_IMAG_RST;
      regs_r.step_real      <= STEP_REAL_RST;
      regs_r.step_imag      <= STEP_IMAG_RST;
      regs_r.max_iterations <= MAX_ITER_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

/* hw/rtl/mbet_mul.sv */
// Shared signed 32x32 multiplier with registered product.
module mbet_mul (
  input  logic                                clk,
  input  mbet_pkg::coord_t                    op_a,
  input  mbet_pkg::coord_t                    op_b,
  output logic signed [mbet_pkg::PROD_W-1:0]  prod
);
  import mbet_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;

  assign prod_nxt = PROD_W'(op_a) * PROD_W'(op_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

/* hw/rtl/mandelbrot_escape_time_pixel.sv */
// Top level: escape-time iteration engine for one pixel at a time.
//
//   port group | dir | handshake           | word
//   in_*       | in  | in_valid/in_ready   | pixel_in_t  (column, row)
//   out_*      | out | out_valid/out_ready | pixel_out_t (position, count, gray, inside)
//   cfg_*      | in  | cfg_we              | register index and 32-bit data
//
// From acceptance to result the states MAP_RE, MAP_IM and LOAD map the pixel to c,
// each iteration runs SQR, SQI, CROSS and UPD on the single 32x32 multiplier (three
// products per iteration), the last test passes SQR, SQI and CROSS on escape or only
// SQR at the limit, and DONE hands the word to the output register once it is free.
// The engine returns to IDLE before it takes the next pixel.
// Reset is synchronous and restores the default view window and limit 400.
// in_ready is high only while idle; a stalled result holds in the output
// register while the next pixel is taken.
module mandelbrot_escape_time_pixel #(
  parameter int FRAC_BITS = 28
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mbet_pkg::pixel_in_t               in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mbet_pkg::pixel_out_t              out_data,
  input  logic                              cfg_we,
  input  logic [mbet_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mbet_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mbet_pkg::*;

  localparam int R2_W  = PROD_W - FRAC_BITS;
  localparam int SUM_W = PROD_W + 1;

  cfg_regs_t regs;

  state_t state_r;
  state_t state_nxt;

  logic [PIXEL_INDEX_BITS-1:0] col_r;
  logic [PIXEL_INDEX_BITS-1:0] row_r;
  coord_t                      cr_r;
  coord_t                      ci_r;
  coord_t                      zr_r;
  coord_t                      zi_r;
  logic [R2_W-1:0]             r2_r;
  logic [R2_W-1:0]             i2_r;
  logic [ITER_BITS-1:0]        count_r;
  logic                        inside_r;
  logic                        out_valid_r;
  pixel_out_t                  out_data_r;

  coord_t                   op_a;
  coord_t                   op_b;
  logic signed [PROD_W-1:0] prod;
  logic                     load_out;
  logic                     out_free;

  logic [R2_W-1:0]          i2_now;
  logic [SUM_W-1:0]         mag_sum;
  logic [SUM_W-1:0]         mag_limit;
  logic                     escape;
  logic                     at_limit;
  logic signed [WIDE_W-1:0] prod_w;
  logic signed [WIDE_W-1:0] cr_sum;
  logic signed [WIDE_W-1:0] ci_sum;
  logic signed [WIDE_W-1:0] nr_sum;
  logic signed [WIDE_W-1:0] ni_sum;
  logic signed [PROD_W-1:0] cross_shift;

  mbet_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  mbet_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign prod_w    = {{(WIDE_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign cr_sum    = {{(WIDE_W-COORD_W){regs.left_real[COORD_W-1]}}, regs.left_real} + prod_w;
  assign ci_sum    = {{(WIDE_W-COORD_W){regs.top_imag[COORD_W-1]}}, regs.top_imag} - prod_w;
  assign i2_now    = prod[PROD_W-1:FRAC_BITS];
  assign mag_sum   = SUM_W'(r2_r) + SUM_W'(i2_now);
  assign mag_limit = SUM_W'(4) << FRAC_BITS;
  assign escape    = mag_sum > mag_limit;
  assign at_limit  = count_r == regs.max_iterations;
  assign cross_shift = prod >>> (FRAC_BITS - 1);
  assign nr_sum    = $signed(WIDE_W'(r2_r)) - $signed(WIDE_W'(i2_r))
                   + {{(WIDE_W-COORD_W){cr_r[COORD_W-1]}}, cr_r};
  assign ni_sum    = {{(WIDE_W-PROD_W){cross_shift[PROD_W-1]}}, cross_shift}
                   + {{(WIDE_W-COORD_W){ci_r[COORD_W-1]}}, ci_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_MAP_RE;
      S_MAP_RE: state_nxt = S_MAP_IM;
      S_MAP_IM: state_nxt = S_LOAD;
      S_LOAD:   state_nxt = S_SQR;
      S_SQR:    state_nxt = at_limit ? S_DONE : S_SQI;
      S_SQI:    state_nxt = S_CROSS;
      S_CROSS:  state_nxt = escape ? S_DONE : S_UPD;
      S_UPD:    state_nxt = S_SQR;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    op_a     = zr_r;
    op_b     = zr_r;
    case (state_r)
      S_IDLE:   in_ready = 1'b1;
      S_MAP_RE: begin
        op_a = COORD_W'(col_r);
        op_b = regs.step_real;
      end
      S_MAP_IM: begin
        op_a = COORD_W'(row_r);
        op_b = regs.step_imag;
      end
      S_SQR: begin
        op_a = zr_r;
        op_b = zr_r;
      end
      S_SQI: begin
        op_a = zi_r;
        op_b = zi_r;
      end
      S_CROSS: begin
        op_a = zr_r;
        op_b = zi_r;
      end
      S_DONE:   load_out = out_free;
      default: begin
        op_a = zr_r;
        op_b = zr_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        col_r <= in_data.pixel_col;
        row_r <= in_data.pixel_row;
      end
      S_MAP_IM: cr_r <= sat_coord(cr_sum);
      S_LOAD: begin
        ci_r    <= sat_coord(ci_sum);
        zr_r    <= '0;
        zi_r    <= '0;
        count_r <= '0;
      end
      S_SQR:   inside_r <= 1'b1;
      S_SQI:   r2_r <= prod[PROD_W-1:FRAC_BITS];
      S_CROSS: begin
        i2_r     <= i2_now;
        inside_r <= 1'b0;
      end
      S_UPD: begin
        zr_r    <= sat_coord(nr_sum);
        zi_r    <= sat_coord(ni_sum);
        count_r <= count_r + 1'b1;
      end
      default: begin
        cr_r <= cr_r;
      end
    endcase
    if (load_out) begin
      out_data_r.pixel_col_out   <= col_r;
      out_data_r.pixel_row_out   <= row_r;
      out_data_r.iteration_count <= count_r;
      out_data_r.gray_level      <= count_r[GRAY_W-1:0];
      out_data_r.inside_set      <= inside_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hw/rtl/mbet_chk.sv */
// Port-level checks for the escape-time pixel engine, bound to the top level.
module mbet_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input mbet_pkg::pixel_out_t              out_data
);
  import mbet_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed or dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while a pixel is in flight");

  a_gray_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.gray_level == out_data.iteration_count[GRAY_W-1:0])
    else $error("gray level differs from low bits of iteration count");

  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not leave engine idle and empty");

endmodule

bind mandelbrot_escape_time_pixel mbet_chk u_mbet_chk (.*);
